// ===== sv/indexed_doubly_linked_list_macros.svh =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list assertion macros
// Shorthands for the clocked, reset-gated properties of the checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// Check cons in the same cycle as ante; needs clk and rst_n in scope.
`define IDLL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; needs clk and rst_n in scope.
`define IDLL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list package
// Command and status codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int HOPS_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADVANCE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_OCC  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OFF_END  = 2'd3;

endpackage

// ===== sv/idll_ram.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = idll_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = idll_pkg::SLOTS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/indexed_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list
// Slot pool holding one doubly linked list, driven by list commands.
// ----------------------------------------------------------------------------
// Usage: one command word enters on in_* (tvalid/tready), one result word
// leaves on out_* for every command. Elements are named by slot index;
// the value SLOTS means "no slot" in every slot field.
// Commands work one at a time: in_tready is high only while the block is
// idle. Push back, push front and insert end with a wrapping scan for the
// next free slot, one link read a cycle; advance reads one link per hop.
// A full pool, an out-of-range slot or a no-op skips the link memory, and
// an unoccupied target ends after its one link read. All link traffic goes
// through the single read port of the link memory, each link update as a
// read-modify-write.
// Reset: a clearing pass writes all SLOTS link entries empty, one per
// cycle; in_tready stays low during the pass. Clear reruns the pass.
// A stalled out_tready holds the result in the output register; the next
// command is still accepted and waits only for its own result slot.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
  parameter int SLOTS      = idll_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF,
  localparam int SW        = $clog2(SLOTS + 1),
  localparam int IN_W      = ((idll_pkg::CMD_W + SW + DATA_WIDTH + idll_pkg::HOPS_W + 7) / 8) * 8,
  localparam int OUT_W     = ((idll_pkg::STATUS_W + 3 * SW + DATA_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // command, slot, item_data, hops
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status, result_slot, result_data, head_slot, tail_slot
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CW = idll_pkg::CMD_W;
  localparam int HW = idll_pkg::HOPS_W;
  localparam int TW = idll_pkg::STATUS_W;
  localparam int DW = DATA_WIDTH;
  localparam int IW = $clog2(SLOTS);
  // link entry: occupied bit, prev link, next link
  localparam int LW = 1 + 2 * SW;

  localparam logic [SW-1:0] NONE      = SW'(SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_TARGET  = 4'd3;
  localparam logic [3:0] S_ADVANCE = 4'd4;
  localparam logic [3:0] S_PA_RD   = 4'd5;
  localparam logic [3:0] S_PA_WR   = 4'd6;
  localparam logic [3:0] S_PB_RD   = 4'd7;
  localparam logic [3:0] S_PB_WR   = 4'd8;
  localparam logic [3:0] S_SEARCH  = 4'd9;
  localparam logic [3:0] S_FETCH   = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  // one pending link fix-up: set the next or prev field of one entry
  typedef struct packed {
    logic          en;
    logic          set_next;
    logic [IW-1:0] addr;
    logic [SW-1:0] val;
  } patch_t;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  logic [3:0]    state_r,   state_nxt;
  logic [CW-1:0] cmd_r,     cmd_nxt;
  logic [SW-1:0] slot_r,    slot_nxt;
  logic [DW-1:0] data_r,    data_nxt;
  logic [HW-1:0] hops_r,    hops_nxt;
  logic [SW-1:0] head_r,    head_nxt;
  logic [SW-1:0] tail_r,    tail_nxt;
  logic [SW-1:0] free_r,    free_nxt;
  logic [SW-1:0] res_r,     res_nxt;
  logic [TW-1:0] status_r,  status_nxt;
  logic [SW-1:0] cur_r,     cur_nxt;
  logic          clr_cmd_r, clr_cmd_nxt;
  logic [SW-1:0] cnt_r,     cnt_nxt;
  logic [IW-1:0] scan_r,    scan_nxt;
  logic [IW-1:0] chk_r,     chk_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  patch_t        pa_r,      pa_nxt;
  patch_t        pb_r,      pb_nxt;

  logic          out_valid_r,  out_valid_nxt;
  logic [TW-1:0] out_status_r, out_status_nxt;
  logic [SW-1:0] out_res_r,    out_res_nxt;
  logic [DW-1:0] out_data_r,   out_data_nxt;
  logic [SW-1:0] out_head_r,   out_head_nxt;
  logic [SW-1:0] out_tail_r,   out_tail_nxt;

  logic          patch_end;
  logic [SW-1:0] hop_link;

  // link memory port
  logic          lk_we, lk_re;
  logic [IW-1:0] lk_waddr, lk_raddr;
  logic [LW-1:0] lk_wdata, lk_rdata;
  logic          rd_occ;
  logic [SW-1:0] rd_prev, rd_next;

  // payload memory port
  logic          pl_we, pl_re;
  logic [IW-1:0] pl_waddr, pl_raddr;
  logic [DW-1:0] pl_wdata, pl_rdata;

  idll_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  idll_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  assign rd_occ  = lk_rdata[LW-1];
  assign rd_prev = lk_rdata[2*SW-1:SW];
  assign rd_next = lk_rdata[SW-1:0];

  assign pl_wdata = data_r;
  assign pl_raddr = res_r[IW-1:0];

  // follow next links for positive hop counts, prev links for negative
  assign hop_link = hops_r[HW-1] ? rd_prev : rd_next;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_tail_r, out_head_r, out_data_r, out_res_r, out_status_r});

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    data_nxt       = data_r;
    hops_nxt       = hops_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    cur_nxt        = cur_r;
    clr_cmd_nxt    = clr_cmd_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    chk_vld_nxt    = chk_vld_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    out_data_nxt   = out_data_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    patch_end      = 1'b0;
    lk_we          = 1'b0;
    lk_waddr       = '0;
    lk_wdata       = '0;
    lk_re          = 1'b0;
    lk_raddr       = '0;
    pl_we          = 1'b0;
    pl_waddr       = free_r[IW-1:0];
    pl_re          = 1'b0;

    case (state_r)
      // write every link entry empty, one a cycle
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = cnt_r[IW-1:0];
        lk_wdata = {1'b0, NONE, NONE};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = clr_cmd_r ? S_OUT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[CW-1:0];
          slot_nxt  = in_tdata[CW +: SW];
          data_nxt  = in_tdata[CW+SW +: DW];
          hops_nxt  = in_tdata[CW+SW+DW +: HW];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = idll_pkg::STAT_OK;
        res_nxt    = NONE;
        state_nxt  = S_OUT;
        case (cmd_r)
          idll_pkg::CMD_PUSH_BACK, idll_pkg::CMD_PUSH_FRONT: begin
            if (free_r >= NONE) begin
              status_nxt = idll_pkg::STAT_FULL;
            end else begin
              // write the new entry now, fix the old end entry afterward
              lk_we       = 1'b1;
              lk_waddr    = free_r[IW-1:0];
              pl_we       = 1'b1;
              res_nxt     = free_r;
              pb_nxt.en   = 1'b0;
              pa_nxt.val  = free_r;
              state_nxt   = S_PA_RD;
              if (cmd_r == idll_pkg::CMD_PUSH_BACK) begin
                lk_wdata        = {1'b1, tail_r, NONE};
                pa_nxt.en       = (tail_r != NONE);
                pa_nxt.set_next = 1'b1;
                pa_nxt.addr     = tail_r[IW-1:0];
                tail_nxt        = free_r;
                if (tail_r == NONE) begin
                  head_nxt = free_r;
                end
              end else begin
                lk_wdata        = {1'b1, NONE, head_r};
                pa_nxt.en       = (head_r != NONE);
                pa_nxt.set_next = 1'b0;
                pa_nxt.addr     = head_r[IW-1:0];
                head_nxt        = free_r;
                if (head_r == NONE) begin
                  tail_nxt = free_r;
                end
              end
            end
          end
          idll_pkg::CMD_INSERT: begin
            if (free_r >= NONE) begin
              status_nxt = idll_pkg::STAT_FULL;
            end else if (slot_r >= NONE) begin
              status_nxt = idll_pkg::STAT_NOT_OCC;
            end else begin
              lk_re     = 1'b1;
              lk_raddr  = slot_r[IW-1:0];
              state_nxt = S_TARGET;
            end
          end
          idll_pkg::CMD_ERASE: begin
            // erase of "no slot" is a quiet no-op
            if (slot_r > NONE) begin
              status_nxt = idll_pkg::STAT_NOT_OCC;
            end else if (slot_r != NONE) begin
              lk_re     = 1'b1;
              lk_raddr  = slot_r[IW-1:0];
              state_nxt = S_TARGET;
            end
          end
          idll_pkg::CMD_ADVANCE: begin
            if (slot_r >= NONE) begin
              status_nxt = idll_pkg::STAT_NOT_OCC;
            end else begin
              lk_re     = 1'b1;
              lk_raddr  = slot_r[IW-1:0];
              state_nxt = S_TARGET;
            end
          end
          idll_pkg::CMD_CLEAR: begin
            head_nxt    = NONE;
            tail_nxt    = NONE;
            free_nxt    = '0;
            clr_cmd_nxt = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = S_CLEAR;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      // link entry of the target slot is on the read port
      S_TARGET: begin
        pa_nxt.en = 1'b0;
        pb_nxt.en = 1'b0;
        if (!rd_occ) begin
          status_nxt = idll_pkg::STAT_NOT_OCC;
          state_nxt  = S_OUT;
        end else begin
          case (cmd_r)
            idll_pkg::CMD_INSERT: begin
              lk_we           = 1'b1;
              lk_waddr        = free_r[IW-1:0];
              lk_wdata        = {1'b1, rd_prev, slot_r};
              pl_we           = 1'b1;
              res_nxt         = free_r;
              pa_nxt.en       = 1'b1;
              pa_nxt.set_next = 1'b0;
              pa_nxt.addr     = slot_r[IW-1:0];
              pa_nxt.val      = free_r;
              pb_nxt.en       = (slot_r != head_r) && (rd_prev < NONE);
              pb_nxt.set_next = 1'b1;
              pb_nxt.addr     = rd_prev[IW-1:0];
              pb_nxt.val      = free_r;
              if (slot_r == head_r) begin
                head_nxt = free_r;
              end
              state_nxt = S_PA_RD;
            end
            idll_pkg::CMD_ERASE: begin
              // drop the occupied bit, then relink the neighbors
              lk_we     = 1'b1;
              lk_waddr  = slot_r[IW-1:0];
              lk_wdata  = {1'b0, rd_prev, rd_next};
              free_nxt  = slot_r;
              state_nxt = S_PA_RD;
              if (slot_r == head_r) begin
                if (rd_next < NONE) begin
                  head_nxt        = rd_next;
                  res_nxt         = rd_next;
                  pa_nxt.en       = 1'b1;
                  pa_nxt.set_next = 1'b0;
                  pa_nxt.addr     = rd_next[IW-1:0];
                  pa_nxt.val      = NONE;
                end else begin
                  head_nxt = NONE;
                  tail_nxt = NONE;
                end
              end else if (slot_r == tail_r) begin
                if (rd_prev < NONE) begin
                  tail_nxt        = rd_prev;
                  pa_nxt.en       = 1'b1;
                  pa_nxt.set_next = 1'b1;
                  pa_nxt.addr     = rd_prev[IW-1:0];
                  pa_nxt.val      = NONE;
                end else begin
                  head_nxt = NONE;
                  tail_nxt = NONE;
                end
              end else begin
                res_nxt         = rd_next;
                pa_nxt.en       = (rd_next < NONE);
                pa_nxt.set_next = 1'b0;
                pa_nxt.addr     = rd_next[IW-1:0];
                pa_nxt.val      = rd_prev;
                pb_nxt.en       = (rd_prev < NONE);
                pb_nxt.set_next = 1'b1;
                pb_nxt.addr     = rd_prev[IW-1:0];
                pb_nxt.val      = rd_next;
              end
            end
            default: begin
              // advance: read data holds, walk starts next cycle
              cur_nxt   = slot_r;
              state_nxt = S_ADVANCE;
            end
          endcase
        end
      end

      // one hop per cycle; read port holds the entry of cur_r
      S_ADVANCE: begin
        if (!rd_occ) begin
          status_nxt = idll_pkg::STAT_OFF_END;
          state_nxt  = S_OUT;
        end else if (hops_r == '0) begin
          res_nxt   = cur_r;
          state_nxt = S_FETCH;
        end else if (hop_link >= NONE) begin
          status_nxt = idll_pkg::STAT_OFF_END;
          state_nxt  = S_OUT;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = hop_link[IW-1:0];
          cur_nxt  = hop_link;
          hops_nxt = hops_r[HW-1] ? hops_r + 1'b1 : hops_r - 1'b1;
        end
      end

      S_PA_RD: begin
        if (pa_r.en) begin
          lk_re     = 1'b1;
          lk_raddr  = pa_r.addr;
          state_nxt = S_PA_WR;
        end else begin
          state_nxt = S_PB_RD;
        end
      end

      S_PA_WR: begin
        lk_we     = 1'b1;
        lk_waddr  = pa_r.addr;
        lk_wdata  = pa_r.set_next ? {rd_occ, rd_prev, pa_r.val}
                                  : {rd_occ, pa_r.val, rd_next};
        state_nxt = S_PB_RD;
      end

      S_PB_RD: begin
        if (pb_r.en) begin
          lk_re     = 1'b1;
          lk_raddr  = pb_r.addr;
          state_nxt = S_PB_WR;
        end else begin
          patch_end = 1'b1;
        end
      end

      S_PB_WR: begin
        lk_we     = 1'b1;
        lk_waddr  = pb_r.addr;
        lk_wdata  = pb_r.set_next ? {rd_occ, rd_prev, pb_r.val}
                                  : {rd_occ, pb_r.val, rd_next};
        patch_end = 1'b1;
      end

      // wrapping free scan: issue one read a cycle, test the previous one
      S_SEARCH: begin
        lk_re       = 1'b1;
        lk_raddr    = scan_r;
        scan_nxt    = wrap_inc(scan_r);
        chk_nxt     = scan_r;
        chk_vld_nxt = 1'b1;
        if (chk_vld_r) begin
          if (!rd_occ) begin
            free_nxt    = SW'(chk_r);
            cnt_nxt     = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_FETCH;
          end else if (cnt_r == LAST_SLOT) begin
            free_nxt    = NONE;
            cnt_nxt     = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_FETCH;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_FETCH: begin
        pl_re     = (res_r < NONE);
        state_nxt = S_OUT;
      end

      // load the result once the output register is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_res_nxt    = res_r;
          out_data_nxt   = (res_r < NONE) ? pl_rdata : '0;
          out_head_nxt   = head_r;
          out_tail_nxt   = tail_r;
          clr_cmd_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // after the link fix-ups: erase reports at once, allocations rescan
    if (patch_end) begin
      if (cmd_r == idll_pkg::CMD_ERASE) begin
        state_nxt = S_FETCH;
      end else begin
        scan_nxt    = wrap_inc(free_r[IW-1:0]);
        cnt_nxt     = '0;
        chk_vld_nxt = 1'b0;
        state_nxt   = S_SEARCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= NONE;
      tail_r      <= NONE;
      free_r      <= '0;
      clr_cmd_r   <= 1'b0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      pa_r        <= '0;
      pb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      pa_r        <= pa_nxt;
      pb_r        <= pb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    data_r       <= data_nxt;
    hops_r       <= hops_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    cur_r        <= cur_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
    out_data_r   <= out_data_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
  end

endmodule

// ===== sv/idll_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list checker
// Port-level properties of the list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_doubly_linked_list_macros.svh"

module idll_checker #(
  parameter int SLOTS      = idll_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF,
  localparam int SW        = $clog2(SLOTS + 1),
  localparam int OUT_W     = ((idll_pkg::STATUS_W + 3 * SW + DATA_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int TW = idll_pkg::STATUS_W;
  localparam logic [SW-1:0] NONE = SW'(SLOTS);

  logic [TW-1:0]         out_status;
  logic [SW-1:0]         out_res;
  logic [DATA_WIDTH-1:0] out_data;
  logic [SW-1:0]         out_head;
  logic [SW-1:0]         out_tail;

  assign out_status = out_tdata[TW-1:0];
  assign out_res    = out_tdata[TW +: SW];
  assign out_data   = out_tdata[TW+SW +: DATA_WIDTH];
  assign out_head   = out_tdata[TW+SW+DATA_WIDTH +: SW];
  assign out_tail   = out_tdata[TW+2*SW+DATA_WIDTH +: SW];

  // the clearing pass keeps both channels quiet right after reset
  `IDLL_ASSERT_IMP(a_reset_quiet, $past(!rst_n), !out_tvalid && !in_tready, "busy after reset")

  // one command at a time
  `IDLL_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second word accepted")

  // a failed command reports no slot and no payload
  `IDLL_ASSERT_IMP(a_err_no_slot, out_tvalid && (out_status != idll_pkg::STAT_OK), (out_res == NONE) && (out_data == '0), "error with a slot")

  // list is empty at both ends or at neither
  `IDLL_ASSERT_IMP(a_ends_agree, out_tvalid, (out_head == NONE) == (out_tail == NONE), "head and tail disagree")

  `IDLL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word dropped")

endmodule

bind indexed_doubly_linked_list idll_checker #(
  .SLOTS      (SLOTS),
  .DATA_WIDTH (DATA_WIDTH)
) u_idll_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/indexed_doubly_linked_list_tb.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked list testbench
// Drives list commands into the slot pool and checks every result word
// against a cycle-free list model kept alongside the stream. A directed table
// runs first, then three random phases with different backpressure patterns.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idll_pkg::*;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int DW        = DATA_WIDTH_DEF;
  localparam int SW        = $clog2(SLOTS + 1);
  localparam int IN_W      = ((CMD_W + SW + DW + HOPS_W + 7) / 8) * 8;
  localparam int OUT_W     = ((STATUS_W + 3 * SW + DW + 7) / 8) * 8;
  localparam int NONE_SLOT = SLOTS;
  localparam int RAND_ITEMS_PER_PHASE = 470;
  localparam int TAIL_CYCLES = 40;

  // Codes the package leaves unassigned.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SW-1:0]     slot;
    logic [DW-1:0]     data;
    logic [HOPS_W-1:0] hops;
  } list_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SW-1:0]       rslot;
    logic [DW-1:0]       rdata;
    logic [SW-1:0]       head;
    logic [SW-1:0]       tail;
  } list_result_t;

  typedef struct {
    list_cmd_t    c;
    bit           typed;
    list_result_t r;
  } dir_row_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  // command, slot, item_data, hops
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // status, result_slot, result_data, head_slot, tail_slot
  logic [OUT_W-1:0] out_tdata;

  indexed_doubly_linked_list #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the list: payloads, links, occupancy and the three pointers.
  logic [DW-1:0]    lst_data [SLOTS];
  logic [SW-1:0]    lst_fwd  [SLOTS];
  logic [SW-1:0]    lst_back [SLOTS];
  logic [SLOTS-1:0] lst_occ  = '0;
  logic [SW-1:0]    lst_head = SW'(NONE_SLOT);
  logic [SW-1:0]    lst_tail = SW'(NONE_SLOT);
  logic [SW-1:0]    lst_free = '0;

  list_result_t pending_results [$];
  dir_row_t     dir_rows [$];

  int err_cnt;
  int words_sent;
  int words_checked;
  int status_seen [4];
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("%0t ns: timeout, %0d results still pending", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // List model
  // ---------------------------------------------------------------------------
  function automatic bit slot_used(int s);
    return s < NONE_SLOT && lst_occ[s];
  endfunction

  // Wrap around from the slot after the free pointer; none if the pool is full.
  function automatic void seek_free_slot();
    int start;
    int cand;
    bit found;
    start = (lst_free < NONE_SLOT) ? int'(lst_free) : 0;
    found = 1'b0;
    lst_free = SW'(NONE_SLOT);
    for (int k = 1; k <= NONE_SLOT; k++) begin
      cand = (start + k) % NONE_SLOT;
      if (!found && !lst_occ[cand]) begin
        lst_free = SW'(cand);
        found = 1'b1;
      end
    end
  endfunction

  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    logic [STATUS_W-1:0] st;
    int s, n, p, nx, pv, cur, step_to, h, res;
    s   = int'(c.slot);
    h   = {{(32-HOPS_W){c.hops[HOPS_W-1]}}, c.hops};
    st  = STAT_OK;
    res = NONE_SLOT;
    case (c.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
        if (lst_free >= NONE_SLOT) begin
          st = STAT_FULL;
        end else if (c.cmd == CMD_INSERT && !slot_used(s)) begin
          st = STAT_NOT_OCC;
        end else begin
          n = int'(lst_free);
          lst_data[n] = c.data;
          lst_occ[n]  = 1'b1;
          if (c.cmd == CMD_PUSH_BACK) begin
            lst_back[n] = lst_tail;
            lst_fwd[n]  = SW'(NONE_SLOT);
            if (slot_used(int'(lst_tail))) lst_fwd[lst_tail] = SW'(n);
            else lst_head = SW'(n);
            lst_tail = SW'(n);
          end else if (c.cmd == CMD_PUSH_FRONT) begin
            lst_fwd[n]  = lst_head;
            lst_back[n] = SW'(NONE_SLOT);
            if (slot_used(int'(lst_head))) lst_back[lst_head] = SW'(n);
            else lst_tail = SW'(n);
            lst_head = SW'(n);
          end else begin
            // Link the new slot in ahead of the target.
            p = int'(lst_back[s]);
            lst_back[n] = SW'(p);
            lst_fwd[n]  = SW'(s);
            if (s == lst_head) lst_head = SW'(n);
            else if (p < NONE_SLOT) lst_fwd[p] = SW'(n);
            lst_back[s] = SW'(n);
          end
          res = n;
          seek_free_slot();
        end
      end
      CMD_ERASE: begin
        if (s == NONE_SLOT) begin
          st = STAT_OK;
        end else if (!slot_used(s)) begin
          st = STAT_NOT_OCC;
        end else begin
          nx = int'(lst_fwd[s]);
          pv = int'(lst_back[s]);
          if (s == lst_head) begin
            if (nx < NONE_SLOT) begin
              lst_head     = SW'(nx);
              lst_back[nx] = SW'(NONE_SLOT);
              res          = nx;
            end else begin
              lst_head = SW'(NONE_SLOT);
              lst_tail = SW'(NONE_SLOT);
            end
          end else if (s == lst_tail) begin
            // The tail has no successor to report.
            if (pv < NONE_SLOT) begin
              lst_tail    = SW'(pv);
              lst_fwd[pv] = SW'(NONE_SLOT);
            end else begin
              lst_head = SW'(NONE_SLOT);
              lst_tail = SW'(NONE_SLOT);
            end
          end else begin
            if (nx < NONE_SLOT) lst_back[nx] = SW'(pv);
            if (pv < NONE_SLOT) lst_fwd[pv] = SW'(nx);
            res = nx;
          end
          lst_occ[s] = 1'b0;
          lst_free   = SW'(s);
        end
      end
      CMD_ADVANCE: begin
        if (!slot_used(s)) begin
          st = STAT_NOT_OCC;
        end else begin
          cur = s;
          while (h != 0 && st == STAT_OK) begin
            if (h > 0) begin
              step_to = int'(lst_fwd[cur]);
              h--;
            end else begin
              step_to = int'(lst_back[cur]);
              h++;
            end
            if (!slot_used(step_to)) st = STAT_OFF_END;
            else cur = step_to;
          end
          if (st == STAT_OK) res = cur;
        end
      end
      CMD_CLEAR: begin
        lst_occ  = '0;
        lst_head = SW'(NONE_SLOT);
        lst_tail = SW'(NONE_SLOT);
        lst_free = '0;
      end
      default: begin
      end
    endcase
    if (!slot_used(res)) res = NONE_SLOT;
    r.status = st;
    r.rslot  = SW'(res);
    r.rdata  = (res < NONE_SLOT) ? lst_data[res] : '0;
    r.head   = lst_head;
    r.tail   = lst_tail;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Random occupied slot, or none when the list is empty.
  function automatic int pick_occupied();
    int cnt, k, sel;
    cnt = 0;
    sel = NONE_SLOT;
    for (int i = 0; i < SLOTS; i++) if (lst_occ[i]) cnt++;
    if (cnt != 0) begin
      k = $urandom_range(0, cnt - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (lst_occ[i]) begin
          if (k == 0) sel = i;
          k--;
        end
      end
    end
    return sel;
  endfunction

  // Mostly live slots, some none, some anything the field can hold.
  function automatic logic [SW-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && lst_occ != '0) return SW'(pick_occupied());
    if (r < 88) return SW'(NONE_SLOT);
    return SW'($urandom_range(0, (1 << SW) - 1));
  endfunction

  function automatic list_cmd_t random_list_cmd();
    list_cmd_t c;
    int r;
    r      = $urandom_range(0, 99);
    c.slot = pick_target();
    c.data = $urandom;
    if ($urandom_range(0, 1)) c.hops = HOPS_W'($urandom_range(0, (1 << HOPS_W) - 1));
    else c.hops = HOPS_W'($urandom_range(0, 8) - 4);
    if (r < 14)      c.cmd = CMD_PUSH_BACK;
    else if (r < 28) c.cmd = CMD_PUSH_FRONT;
    else if (r < 40) c.cmd = CMD_INSERT;
    else if (r < 70) c.cmd = CMD_ERASE;
    else if (r < 94) c.cmd = CMD_ADVANCE;
    else if (r < 96) c.cmd = CMD_CLEAR;
    else if (r < 98) c.cmd = CMD_SPARE_6;
    else             c.cmd = CMD_SPARE_7;
    return c;
  endfunction

  // Present one command word, wait for the handshake, then log its expectation.
  task automatic issue_list_cmd(list_cmd_t c, bit typed, list_result_t typed_r);
    int gap;
    list_result_t r;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({c.hops, c.data, c.slot, c.cmd});
    do @(posedge clk); while (!in_tready);
    r = apply_list_cmd(c);
    pending_results.push_back(typed ? typed_r : r);
    words_sent++;
  endtask

  task automatic send_random(list_cmd_t c);
    list_result_t unused_r;
    unused_r = '{default: '0};
    issue_list_cmd(c, 1'b0, unused_r);
  endtask

  // Drop valid and hold until every pending result has been seen.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(logic [CMD_W-1:0] cmd, int slot, logic [DW-1:0] data, int hops,
                         bit typed, logic [STATUS_W-1:0] st, int rslot,
                         logic [DW-1:0] rdata, int head, int tail);
    dir_row_t row;
    row.c.cmd    = cmd;
    row.c.slot   = SW'(slot);
    row.c.data   = data;
    row.c.hops   = HOPS_W'(hops);
    row.typed    = typed;
    row.r.status = st;
    row.r.rslot  = SW'(rslot);
    row.r.rdata  = rdata;
    row.r.head   = SW'(head);
    row.r.tail   = SW'(tail);
    dir_rows.push_back(row);
  endtask

  // Push until the pool is full, then push twice more to hit the full status.
  task automatic fill_pool();
    list_cmd_t c;
    int extra;
    extra = 0;
    while (extra < 2) begin
      if (lst_free >= NONE_SLOT) extra++;
      c = random_list_cmd();
      case ($urandom_range(0, 2))
        0: c.cmd = CMD_PUSH_BACK;
        1: c.cmd = CMD_PUSH_FRONT;
        default: begin
          c.cmd  = CMD_INSERT;
          c.slot = (lst_occ != '0) ? SW'(pick_occupied()) : SW'(NONE_SLOT);
        end
      endcase
      send_random(c);
    end
  endtask

  // Erase live slots in random order until the list is empty.
  task automatic empty_pool();
    list_cmd_t c;
    while (lst_head != NONE_SLOT) begin
      c      = random_list_cmd();
      c.cmd  = CMD_ERASE;
      c.slot = SW'(pick_occupied());
      send_random(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(string name, logic [DW-1:0] exp, logic [DW-1:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word 0x%0h with no command pending", $time, out_tdata);
        err_cnt++;
      end else begin
        exp = pending_results.pop_front();
        check_field("status", DW'(exp.status), DW'(out_tdata[1:0]));
        check_field("result_slot", DW'(exp.rslot), DW'(out_tdata[2 +: SW]));
        check_field("result_data", exp.rdata, out_tdata[2 + SW +: DW]);
        check_field("head_slot", DW'(exp.head), DW'(out_tdata[2 + SW + DW +: SW]));
        check_field("tail_slot", DW'(exp.tail), DW'(out_tdata[2 + 2 * SW + DW +: SW]));
        words_checked++;
        status_seen[exp.status]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    err_cnt       = 0;
    words_sent    = 0;
    words_checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    send_idle_pct = 27;
    recv_idle_pct = 46;

    // Directed table. Typed rows are obvious from the empty or trivial list;
    // the rest take the model's answer.
    // Empty list: every target is dead, erase of none is a no-op.
    add_row(CMD_ADVANCE, 0, '0, 0, 1, STAT_NOT_OCC, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    add_row(CMD_ERASE, NONE_SLOT, '0, 0, 1, STAT_OK, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    add_row(CMD_INSERT, NONE_SLOT, 32'hDEAD_BEEF, 0, 1, STAT_NOT_OCC, NONE_SLOT, '0,
            NONE_SLOT, NONE_SLOT);
    add_row(CMD_ERASE, 31, '0, 0, 1, STAT_NOT_OCC, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    add_row(CMD_ADVANCE, NONE_SLOT, '0, 1, 1, STAT_NOT_OCC, NONE_SLOT, '0,
            NONE_SLOT, NONE_SLOT);
    // First elements land in slots 0 and 1.
    add_row(CMD_PUSH_BACK, 0, 32'hFFFF_FFFF, 0, 1, STAT_OK, 0, 32'hFFFF_FFFF, 0, 0);
    add_row(CMD_PUSH_FRONT, 0, 32'h0, 0, 1, STAT_OK, 1, 32'h0, 1, 0);
    // Advance by zero returns the slot itself.
    add_row(CMD_ADVANCE, 0, '0, 0, 1, STAT_OK, 0, 32'hFFFF_FFFF, 1, 0);
    add_row(CMD_INSERT, 0, 32'h5A5A_A5A5, 0, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_INSERT, 1, 32'h8000_0001, 0, 0, STAT_OK, 0, '0, 0, 0);
    // Hop extremes run off both ends; short hops land inside.
    add_row(CMD_ADVANCE, 3, '0, 15, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_ADVANCE, 0, '0, -16, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_ADVANCE, 3, '0, 3, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_ADVANCE, 0, '0, -3, 0, STAT_OK, 0, '0, 0, 0);
    // Spare command codes change nothing.
    add_row(CMD_SPARE_6, 5, 32'h1234_5678, 7, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_SPARE_7, 31, 32'hFFFF_FFFF, -1, 0, STAT_OK, 0, '0, 0, 0);
    // Erase the tail, a middle element, then the head.
    add_row(CMD_ERASE, 0, '0, 0, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_ERASE, 1, '0, 0, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_ERASE, 3, '0, 0, 0, STAT_OK, 0, '0, 0, 0);
    add_row(CMD_CLEAR, 31, 32'hFFFF_FFFF, -16, 1, STAT_OK, NONE_SLOT, '0,
            NONE_SLOT, NONE_SLOT);
    add_row(CMD_ADVANCE, 2, '0, 0, 1, STAT_NOT_OCC, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    // Lone element: its erase empties the list and reports no successor.
    add_row(CMD_PUSH_BACK, 0, 32'h1234_5678, 0, 1, STAT_OK, 0, 32'h1234_5678, 0, 0);
    add_row(CMD_ERASE, 0, '0, 0, 1, STAT_OK, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    add_row(CMD_ERASE, 0, '0, 0, 1, STAT_NOT_OCC, NONE_SLOT, '0, NONE_SLOT, NONE_SLOT);
    add_row(CMD_ADVANCE, 31, '0, -16, 1, STAT_NOT_OCC, NONE_SLOT, '0,
            NONE_SLOT, NONE_SLOT);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue_list_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

    // Random phases: receiver-heavy idling, sender-heavy idling, no idling.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Let the pipe run dry before each phase.
      wait_results_drained();
      fill_pool();
      for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++) send_random(random_list_cmd());
      empty_pool();
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command words, checked %0d result words", words_sent, words_checked);
    $display("Status tally ok/full/not-occupied/off-end: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/idll_pkg.sv
sv/idll_ram.sv
sv/indexed_doubly_linked_list.sv
sv/idll_checker.sv
verif/indexed_doubly_linked_list_tb.sv
